### hw/rtl/nec_pkg.sv
// ---------------------------------------------------------------------------
// nec_pkg
// Shared types, register indexes and helpers for the NEC IR frame decoder.
// ---------------------------------------------------------------------------
package nec_pkg;

  localparam int INTERVAL_BITS = 16;
  localparam int FRAME_BITS    = 32;
  localparam int ADDR_W        = 5;

  localparam logic [15:0] IV_MASK =
    (INTERVAL_BITS >= 16) ? 16'hFFFF : 16'((32'd1 << INTERVAL_BITS) - 32'd1);

  localparam logic [2:0] REG_START_MIN  = 3'd0;
  localparam logic [2:0] REG_START_MAX  = 3'd1;
  localparam logic [2:0] REG_GAP_MIN    = 3'd2;
  localparam logic [2:0] REG_GAP_MAX    = 3'd3;
  localparam logic [2:0] REG_ONE_MARGIN = 3'd4;
  localparam logic [2:0] REG_TIMEOUT    = 3'd5;

  localparam logic [0:0] OP_EDGE = 1'b0;
  localparam logic [0:0] OP_TICK = 1'b1;

  localparam logic [2:0] CODE_IDLE  = 3'd0;
  localparam logic [2:0] CODE_START = 3'd1;
  localparam logic [2:0] CODE_GAP   = 3'd2;
  localparam logic [2:0] CODE_DATA  = 3'd3;
  localparam logic [2:0] CODE_DONE  = 3'd4;

  typedef enum logic [4:0] {
    PH_IDLE  = 5'b00001,
    PH_START = 5'b00010,
    PH_GAP   = 5'b00100,
    PH_DATA  = 5'b01000,
    PH_DONE  = 5'b10000
  } phase_t;

  typedef struct packed {
    logic [15:0] start_min;
    logic [15:0] start_max;
    logic [15:0] gap_min;
    logic [15:0] gap_max;
    logic [15:0] one_margin;
    logic [7:0]  timeout_ticks;
  } cfg_t;

  typedef struct packed {
    logic        frame_done;
    logic        event_flag;
    logic [15:0] address;
    logic [15:0] command;
    logic [2:0]  decoder_state;
  } result_t;

  function automatic logic [2:0] phase_code(phase_t ph);
    logic [2:0] code;
    case (ph)
      PH_IDLE:  code = CODE_IDLE;
      PH_START: code = CODE_START;
      PH_GAP:   code = CODE_GAP;
      PH_DATA:  code = CODE_DATA;
      PH_DONE:  code = CODE_DONE;
      default:  code = CODE_IDLE;
    endcase
    return code;
  endfunction

endpackage

### hw/rtl/nec_cfg_regs.sv
// ---------------------------------------------------------------------------
// nec_cfg_regs
// APB register file holding the timing windows, bit margin and timeout.
// ---------------------------------------------------------------------------
module nec_cfg_regs (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      psel,
  input  logic                      penable,
  input  logic                      pwrite,
  input  logic [nec_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]               pwdata,
  output logic [31:0]               prdata,
  output logic                      pready,
  output nec_pkg::cfg_t             cfg
);
  import nec_pkg::*;

  cfg_t       cfg_r;
  logic       wr_en;
  logic [2:0] idx;

  assign wr_en  = psel & penable & pwrite;
  assign idx    = paddr[4:2];
  assign pready = 1'b1;
  assign cfg    = cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.start_min     <= 16'd7800;
      cfg_r.start_max     <= 16'd9500;
      cfg_r.gap_min       <= 16'd3800;
      cfg_r.gap_max       <= 16'd4700;
      cfg_r.one_margin    <= 16'd350;
      cfg_r.timeout_ticks <= 8'd80;
    end else if (wr_en) begin
      case (idx)
        REG_START_MIN:  cfg_r.start_min     <= pwdata[15:0];
        REG_START_MAX:  cfg_r.start_max     <= pwdata[15:0];
        REG_GAP_MIN:    cfg_r.gap_min       <= pwdata[15:0];
        REG_GAP_MAX:    cfg_r.gap_max       <= pwdata[15:0];
        REG_ONE_MARGIN: cfg_r.one_margin    <= pwdata[15:0];
        REG_TIMEOUT:    cfg_r.timeout_ticks <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_START_MIN:  prdata = {16'd0, cfg_r.start_min};
      REG_START_MAX:  prdata = {16'd0, cfg_r.start_max};
      REG_GAP_MIN:    prdata = {16'd0, cfg_r.gap_min};
      REG_GAP_MAX:    prdata = {16'd0, cfg_r.gap_max};
      REG_ONE_MARGIN: prdata = {16'd0, cfg_r.one_margin};
      REG_TIMEOUT:    prdata = {24'd0, cfg_r.timeout_ticks};
      default:        prdata = 32'd0;
    endcase
  end

endmodule

### hw/rtl/nec_decode_core.sv
// ---------------------------------------------------------------------------
// nec_decode_core
// Frame state, bit shifter and timeout counter; produces one result per word.
// ---------------------------------------------------------------------------
module nec_decode_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  logic              operation,
  input  logic [15:0]       interval_us,
  input  logic              pin_level,
  input  nec_pkg::cfg_t     cfg,
  output nec_pkg::result_t  result
);
  import nec_pkg::*;

  phase_t      phase_r, phase_nxt;
  logic        half_r, half_nxt;
  logic [5:0]  bits_r, bits_nxt;
  logic [15:0] mark_r, mark_nxt;
  logic [31:0] shift_r, shift_nxt;
  logic [7:0]  ticks_r, ticks_nxt;
  logic [15:0] addr_r, addr_nxt;
  logic [15:0] cmd_r, cmd_nxt;
  logic        event_r, event_nxt;
  logic        done;
  logic [15:0] iv;
  logic [16:0] mark_sum;
  logic        is_one;
  logic [7:0]  ticks_dec;
  logic [5:0]  bits_dec;

  assign iv        = interval_us & IV_MASK;
  assign mark_sum  = {1'b0, mark_r} + {1'b0, cfg.one_margin};
  assign is_one    = {1'b0, iv} > mark_sum;
  assign ticks_dec = ticks_r - 8'd1;
  assign bits_dec  = bits_r - 6'd1;

  always_comb begin
    phase_nxt = phase_r;
    half_nxt  = half_r;
    bits_nxt  = bits_r;
    mark_nxt  = mark_r;
    shift_nxt = shift_r;
    ticks_nxt = ticks_r;
    addr_nxt  = addr_r;
    cmd_nxt   = cmd_r;
    event_nxt = event_r;
    done      = 1'b0;
    if (operation == OP_TICK) begin
      if (phase_r == PH_DATA || phase_r == PH_DONE) begin
        ticks_nxt = ticks_dec;
        if (ticks_dec == 8'd0) begin
          phase_nxt = PH_IDLE;
          half_nxt  = 1'b0;
          shift_nxt = 32'd0;
          addr_nxt  = 16'd0;
          cmd_nxt   = 16'd0;
          event_nxt = 1'b0;
        end
      end
    end else begin
      case (phase_r)
        PH_IDLE: begin
          if (!pin_level) phase_nxt = PH_START;
        end
        PH_START: begin
          if (iv > cfg.start_min && iv < cfg.start_max) begin
            phase_nxt = PH_GAP;
          end else begin
            phase_nxt = PH_IDLE;
            half_nxt  = 1'b0;
            event_nxt = 1'b0;
          end
        end
        PH_GAP: begin
          if (iv > cfg.gap_min && iv < cfg.gap_max) begin
            bits_nxt  = 6'(FRAME_BITS);
            ticks_nxt = cfg.timeout_ticks;
            phase_nxt = PH_DATA;
            addr_nxt  = 16'd0;
            cmd_nxt   = 16'd0;
          end else begin
            phase_nxt = PH_IDLE;
            half_nxt  = 1'b0;
            event_nxt = 1'b0;
          end
        end
        PH_DATA: begin
          if (!half_r) begin
            mark_nxt = iv;
            half_nxt = 1'b1;
          end else begin
            shift_nxt = {is_one, shift_r[31:1]};
            half_nxt  = 1'b0;
            bits_nxt  = bits_dec;
            if (bits_dec == 6'd0) phase_nxt = PH_DONE;
          end
        end
        PH_DONE: begin
          addr_nxt  = shift_r[15:0];
          cmd_nxt   = shift_r[31:16];
          phase_nxt = PH_IDLE;
          half_nxt  = 1'b0;
          shift_nxt = 32'd0;
          event_nxt = 1'b1;
          done      = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      half_r  <= 1'b0;
      bits_r  <= 6'd0;
      mark_r  <= 16'd0;
      shift_r <= 32'd0;
      ticks_r <= 8'd0;
      addr_r  <= 16'd0;
      cmd_r   <= 16'd0;
      event_r <= 1'b0;
    end else if (accept) begin
      phase_r <= phase_nxt;
      half_r  <= half_nxt;
      bits_r  <= bits_nxt;
      mark_r  <= mark_nxt;
      shift_r <= shift_nxt;
      ticks_r <= ticks_nxt;
      addr_r  <= addr_nxt;
      cmd_r   <= cmd_nxt;
      event_r <= event_nxt;
    end
  end

  always_comb begin
    result.frame_done    = done;
    result.event_flag    = event_nxt;
    result.address       = addr_nxt;
    result.command       = cmd_nxt;
    result.decoder_state = phase_code(phase_nxt);
  end

endmodule

### hw/rtl/nec_out_buf.sv
// ---------------------------------------------------------------------------
// nec_out_buf
// Result register with one skid entry between decoder and result channel.
// ---------------------------------------------------------------------------
module nec_out_buf (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              accept,
  input  nec_pkg::result_t  result,
  input  logic              out_stall,
  output logic              out_valid,
  output logic              full,
  output nec_pkg::result_t  out_data
);
  import nec_pkg::*;

  result_t main_r, skid_r;
  logic    main_vld_r, skid_vld_r;
  logic    take;

  assign take      = main_vld_r & ~out_stall;
  assign out_valid = main_vld_r;
  assign full      = skid_vld_r;
  assign out_data  = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_vld_r <= 1'b0;
      skid_vld_r <= 1'b0;
    end else if (take || !main_vld_r) begin
      if (skid_vld_r) begin
        main_vld_r <= 1'b1;
        skid_vld_r <= 1'b0;
      end else begin
        main_vld_r <= accept;
      end
    end else if (accept) begin
      skid_vld_r <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (take || !main_vld_r) begin
      if (skid_vld_r) begin
        main_r <= skid_r;
      end else if (accept) begin
        main_r <= result;
      end
    end else if (accept) begin
      skid_r <= result;
    end
  end

endmodule

### hw/rtl/nec_ir_frame_decoder.sv
// ---------------------------------------------------------------------------
// nec_ir_frame_decoder
// NEC IR frame decoder driven by edge interval and millisecond tick words.
//
//   channel  direction  handshake            payload
//   in_      in         in_valid/in_stall    operation, interval_us, pin_level
//   out_     out        out_valid/out_stall  frame_done, event_flag, address,
//                                            command, decoder_state
//   apb      in/out     psel/penable/pready  paddr, pwdata, prdata
//
// One word per cycle while in_stall is low; each result is registered.
// Decode is a single pass from the state registers into the result register.
// A skid entry keeps input open for one word while out_stall holds output.
// Synchronous active-low reset; no clearing pass.
// ---------------------------------------------------------------------------
module nec_ir_frame_decoder (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_operation,
  input  logic [15:0]                in_interval_us,
  input  logic                       in_pin_level,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_frame_done,
  output logic                       out_event_flag,
  output logic [15:0]                out_address,
  output logic [15:0]                out_command,
  output logic [2:0]                 out_decoder_state,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [nec_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                pwdata,
  output logic [31:0]                prdata,
  output logic                       pready
);
  import nec_pkg::*;

  cfg_t    cfg;
  result_t result;
  result_t out_data;
  logic    accept;
  logic    full;

  assign in_stall = full;
  assign accept   = in_valid & ~full;

  nec_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  nec_decode_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .accept      (accept),
    .operation   (in_operation),
    .interval_us (in_interval_us),
    .pin_level   (in_pin_level),
    .cfg         (cfg),
    .result      (result)
  );

  nec_out_buf u_out (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .result    (result),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .full      (full),
    .out_data  (out_data)
  );

  assign out_frame_done    = out_data.frame_done;
  assign out_event_flag    = out_data.event_flag;
  assign out_address       = out_data.address;
  assign out_command       = out_data.command;
  assign out_decoder_state = out_data.decoder_state;

  a_skid_implies_main: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> out_valid)
    else $error("skid entry held without a result in the output register");

  a_done_sets_flag: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> out_event_flag)
    else $error("completed frame without event flag");

  a_done_returns_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_frame_done) |-> (out_decoder_state == CODE_IDLE))
    else $error("completed frame did not return to idle");

  a_stall_after_full_take: assert property (@(posedge clk) disable iff (!rst_n)
    (in_stall && !out_stall) |=> !in_stall)
    else $error("skid entry not drained after output was taken");

endmodule
